[rtl/core/udpd_pkg.sv]
`timescale 1ns / 1ps

package udpd_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HDR_BYTES   = 8;
    localparam int POS_W       = $clog2(HDR_BYTES);
    localparam int CQ_DEPTH    = 2;
    localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

    // request codes
    localparam logic [1:0] REQ_HDR    = 2'd0;
    localparam logic [1:0] REQ_LISTEN = 2'd1;
    localparam logic [1:0] REQ_FORGET = 2'd2;

    // result kinds, also used as the operation of a queued command
    localparam logic [1:0] KIND_LISTEN_ACK = 2'd0;
    localparam logic [1:0] KIND_FORGET_ACK = 2'd1;
    localparam logic [1:0] KIND_DELIVERY   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  header_byte;
        logic        first_byte;
        logic [15:0] port_key;
        logic [7:0]  handle_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status;
        logic [7:0]  listener_handle;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] datagram_length;
        logic [15:0] checksum_field;
    } out_item_t;

    // port carries the destination port on delivery, the key otherwise
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] port;
        logic [7:0]  handle;
        logic [15:0] src_port;
        logic [15:0] datagram_length;
        logic [15:0] checksum_field;
    } cmd_t;

endpackage

[rtl/core/udpd_cmd_q.sv]
`timescale 1ns / 1ps

module udpd_cmd_q
    import udpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    output logic full,
    input  logic pop,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg;
    logic [CQ_CNT_W-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/udpd_front.sv]
`timescale 1ns / 1ps

module udpd_front
    import udpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       store_reg [HDR_BYTES-1];
    logic [7:0]       store_next [HDR_BYTES-1];
    logic [POS_W-1:0] pos;
    logic             is_hdr;
    logic             last;

    always_comb
    begin
        pos      = item.first_byte ? '0 : pos_reg;
        is_hdr   = accept && (item.req_type == REQ_HDR);
        last     = (pos == POS_W'(HDR_BYTES - 1));
        pos_next = pos_reg;
        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            store_next[i] = store_reg[i];
            if (is_hdr && !last && pos == POS_W'(i))
            begin
                store_next[i] = item.header_byte;
            end
        end
        if (is_hdr)
        begin
            pos_next = last ? '0 : pos + 1'b1;
        end

        cmd.op              = KIND_DELIVERY;
        cmd.port            = item.port_key;
        cmd.handle          = item.handle_in;
        cmd.src_port        = {store_reg[0], store_reg[1]};
        cmd.datagram_length = {store_reg[4], store_reg[5]};
        cmd.checksum_field  = {store_reg[6], item.header_byte};
        cmd_valid           = 1'b0;
        case (item.req_type)
            REQ_HDR:
            begin
                cmd.port  = {store_reg[2], store_reg[3]};
                cmd_valid = is_hdr && last;
            end
            REQ_LISTEN:
            begin
                cmd.op    = KIND_LISTEN_ACK;
                cmd_valid = accept;
            end
            REQ_FORGET:
            begin
                cmd.op    = KIND_FORGET_ACK;
                cmd_valid = accept;
            end
            default:
            begin
                // unknown request: drop
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

[rtl/core/udpd_back.sv]
`timescale 1ns / 1ps

module udpd_back
    import udpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_data
);

    logic [15:0]      port_reg [TABLE_DEPTH];
    logic [7:0]       handle_reg [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    out_item_t        res_reg;
    out_item_t        res_next;

    logic [TABLE_DEPTH-1:0] match;
    logic [TABLE_DEPTH-1:0] shift;
    logic                   hit;
    logic [7:0]             hit_handle;
    logic                   seen;
    logic                   table_full;
    logic                   do_listen;
    logic                   do_forget;

    // take a command when the result register is free or being drained
    assign cmd_pop  = !cmd_empty && (!res_valid_reg || pop);
    assign empty    = !res_valid_reg;
    assign out_data = res_reg;

    always_comb
    begin
        seen       = 1'b0;
        hit_handle = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match[i] = (count_reg > CNT_W'(i)) && (port_reg[i] == cmd.port);
            if (match[i] && !seen)
            begin
                hit_handle = handle_reg[i];
            end
            seen     = seen || match[i];
            // entries from the first match onwards move down on forget
            shift[i] = seen;
        end
        hit        = seen;
        table_full = (count_reg == CNT_W'(TABLE_DEPTH));
        do_listen  = cmd_pop && (cmd.op == KIND_LISTEN_ACK) && !table_full;
        do_forget  = cmd_pop && (cmd.op == KIND_FORGET_ACK) && hit;

        count_next = count_reg;
        if (do_listen)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_forget)
        begin
            count_next = count_reg - 1'b1;
        end

        res_next                 = res_reg;
        res_valid_next           = res_valid_reg && !pop;
        if (cmd_pop)
        begin
            res_valid_next           = 1'b1;
            res_next.result_kind     = cmd.op;
            res_next.listener_handle = '0;
            res_next.src_port        = '0;
            res_next.dst_port        = '0;
            res_next.datagram_length = '0;
            res_next.checksum_field  = '0;
            case (cmd.op)
                KIND_DELIVERY:
                begin
                    res_next.status          = hit ? ST_OK : ST_NO_MATCH;
                    res_next.listener_handle = hit ? hit_handle : 8'd0;
                    res_next.src_port        = cmd.src_port;
                    res_next.dst_port        = cmd.port;
                    res_next.datagram_length = cmd.datagram_length;
                    res_next.checksum_field  = cmd.checksum_field;
                end
                KIND_LISTEN_ACK:
                begin
                    res_next.status = table_full ? ST_FULL : ST_OK;
                end
                KIND_FORGET_ACK:
                begin
                    res_next.status = hit ? ST_OK : ST_NO_MATCH;
                end
                default:
                begin
                    res_next.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (do_listen && count_reg == CNT_W'(i))
            begin
                port_reg[i]   <= cmd.port;
                handle_reg[i] <= cmd.handle;
            end
            else if (do_forget && shift[i] && i < TABLE_DEPTH - 1)
            begin
                port_reg[i]   <= port_reg[(i + 1) % TABLE_DEPTH];
                handle_reg[i] <= handle_reg[(i + 1) % TABLE_DEPTH];
            end
        end
    end

endmodule

[rtl/core/udp_port_demux_table.sv]
`timescale 1ns / 1ps

// UDP header demultiplexer with an ordered listener table of TABLE_DEPTH
// entries. Header bytes, listen and forget requests enter through one
// queue-style port; a new item can be pushed each clock while the command
// queue has room. Header bytes are assembled in the front end; the eighth
// byte, a listen or a forget becomes a command in a two-entry queue, and
// the back end executes one command per cycle, while its output register
// is free or being popped, against the table (all entries compared in
// parallel) and holds the result in that register until it is popped. The
// result is registered when the back end takes the command. The table is
// empty straight after reset; no clearing pass is needed.
module udp_port_demux_table
    import udpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  in_data,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_data
);

    logic cmd_valid;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;
    logic accept;

    assign accept = push && !full;

    udpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    udpd_cmd_q u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_valid),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    udpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

endmodule
